/* rtl/assert_macros.svh */
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

/* rtl/rosi_pkg.sv */
package rosi_pkg;

    // Vector format: three signed fixed-point components packed x, y, z from the low bits.
    localparam int COMP_W    = 20;
    localparam int FRAC_W    = 12;
    localparam int DIST_FRAC = 8;
    localparam int NAXIS     = 3;
    localparam int VEC_W     = NAXIS * COMP_W;
    localparam int EPS_W     = 19;
    localparam int DIST_W    = 32;
    localparam int CFG_W     = 64;
    localparam int ADDR_W    = 5;

    // Datapath widths, all exact.
    localparam int DELTA_W = COMP_W + 1;
    localparam int PE_W    = COMP_W + DELTA_W;
    localparam int PF_W    = 2 * COMP_W;
    localparam int E_W     = PE_W + 2;
    localparam int F_W     = PF_W + 2;
    localparam int N_W     = E_W + 1;
    localparam int D_W     = N_W + DIST_FRAC;
    localparam int DEN_W   = F_W;
    localparam int Q_W     = DIST_W + 2;
    localparam int T_W     = Q_W + 2;

    // Pipeline depth: front stages, divider cells, ordering stage, one stage per axis.
    localparam int FRONT_STG = 5;
    localparam int PIPE_D    = FRONT_STG + Q_W + 1 + NAXIS;

    localparam logic [EPS_W-1:0]  EPS_RESET = EPS_W'(4);
    localparam logic [DIST_W-1:0] FAR_RESET = DIST_W'(25600000);

    // Register map, one register every eight bytes.
    typedef enum logic [1:0] {
        REG_ORIGIN = 2'd0,
        REG_DIR    = 2'd1,
        REG_EPS    = 2'd2,
        REG_FAR    = 2'd3
    } reg_idx_t;

    typedef logic signed [COMP_W-1:0] comp_t;

    typedef struct packed {
        logic [VEC_W-1:0] box_min;
        logic [VEC_W-1:0] box_max;
        logic [VEC_W-1:0] axis_x;
        logic [VEC_W-1:0] axis_y;
        logic [VEC_W-1:0] axis_z;
        logic [VEC_W-1:0] box_position;
    } in_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } out_t;

    // One restoring division in flight.
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   num;
        logic [Q_W-1:0]   quo;
        logic [DEN_W-1:0] den;
    } div_t;

    // Per-axis flags that travel beside the divisions.
    typedef struct packed {
        logic [NAXIS-1:0] par;
        logic [NAXIS-1:0] prej;
        logic [NAXIS-1:0] neg_mn;
        logic [NAXIS-1:0] neg_mx;
        logic [NAXIS-1:0] ovf_mn;
        logic [NAXIS-1:0] ovf_mx;
    } side_t;

    function automatic comp_t get_comp(input logic [VEC_W-1:0] v, input int idx);
        return comp_t'(v[idx*COMP_W +: COMP_W]);
    endfunction

endpackage

/* rtl/rosi_cell.sv */
module rosi_cell
    import rosi_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  div_t d_in,
    output div_t d_out
);

    div_t             d_reg;
    div_t             d_next;
    logic [DEN_W:0]   rr;
    logic [DEN_W:0]   diff;
    logic             ge;

    // One quotient bit: shift in the next dividend bit, then compare and subtract.
    always_comb
    begin
        rr     = {d_in.rem, d_in.num[Q_W-1]};
        diff   = rr - {1'b0, d_in.den};
        ge     = rr >= {1'b0, d_in.den};
        d_next = d_in;
        d_next.rem = ge ? diff[DEN_W-1:0] : rr[DEN_W-1:0];
        d_next.num = {d_in.num[Q_W-2:0], 1'b0};
        d_next.quo = {d_in.quo[Q_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

/* rtl/rosi_div_chain.sv */
module rosi_div_chain
    import rosi_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  div_t first,
    output div_t last
);

    div_t link [0:Q_W];

    assign link[0] = first;

    // One cell per quotient bit, most significant first.
    for (genvar i = 0; i < Q_W; i++)
    begin : g_cell
        rosi_cell u_cell (
            .clk   (clk),
            .en    (en),
            .d_in  (link[i]),
            .d_out (link[i+1])
        );
    end

    assign last = link[Q_W];

endmodule

/* rtl/rosi_front.sv */
module rosi_front
    import rosi_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  in_t              in_data,
    input  logic [VEC_W-1:0] origin,
    input  logic [VEC_W-1:0] direction,
    input  logic [EPS_W-1:0] eps,
    output div_t             div_out [0:2*NAXIS-1],
    output side_t            side
);

    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic signed [PE_W-1:0]    pe_t;
    typedef logic signed [PF_W-1:0]    pf_t;
    typedef logic signed [E_W-1:0]     e_t;
    typedef logic signed [F_W-1:0]     f_t;
    typedef logic signed [N_W-1:0]     n_t;

    // Stage 1: unpacked components and delta = position - origin.
    delta_t delta_reg [NAXIS];
    comp_t  ax_reg  [NAXIS][NAXIS];
    comp_t  mn1_reg [NAXIS];
    comp_t  mx1_reg [NAXIS];
    // Stage 2: products.
    pe_t    pe_reg  [NAXIS][NAXIS];
    pf_t    pf_reg  [NAXIS][NAXIS];
    comp_t  mn2_reg [NAXIS];
    comp_t  mx2_reg [NAXIS];
    // Stage 3: dot products.
    e_t     e_reg   [NAXIS];
    f_t     f_reg   [NAXIS];
    comp_t  mn3_reg [NAXIS];
    comp_t  mx3_reg [NAXIS];
    // Stage 4: numerators, |f| and slab flags.
    n_t               nmn_reg [NAXIS];
    n_t               nmx_reg [NAXIS];
    logic [DEN_W-1:0] af_reg  [NAXIS];
    logic [NAXIS-1:0] sf_reg;
    logic [NAXIS-1:0] par_reg;
    logic [NAXIS-1:0] prej_reg;
    // Stage 5: division setup.
    div_t             div_reg [0:2*NAXIS-1];
    side_t            side_reg;

    logic [VEC_W-1:0] axv [NAXIS];

    assign axv[0] = in_data.axis_x;
    assign axv[1] = in_data.axis_y;
    assign axv[2] = in_data.axis_z;

    // Stage 1 register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NAXIS; i++)
            begin
                delta_reg[i] <= DELTA_W'(get_comp(in_data.box_position, i))
                              - DELTA_W'(get_comp(origin, i));
                mn1_reg[i]   <= get_comp(in_data.box_min, i);
                mx1_reg[i]   <= get_comp(in_data.box_max, i);
                for (int a = 0; a < NAXIS; a++)
                begin
                    ax_reg[a][i] <= get_comp(axv[a], i);
                end
            end
        end
    end

    // Stage 2: axis times delta, and direction times axis.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NAXIS; a++)
            begin
                mn2_reg[a] <= mn1_reg[a];
                mx2_reg[a] <= mx1_reg[a];
                for (int i = 0; i < NAXIS; i++)
                begin
                    pe_reg[a][i] <= PE_W'(ax_reg[a][i]) * PE_W'(delta_reg[i]);
                    pf_reg[a][i] <= PF_W'(get_comp(direction, i)) * PF_W'(ax_reg[a][i]);
                end
            end
        end
    end

    // Stage 3: sums of the products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NAXIS; a++)
            begin
                mn3_reg[a] <= mn2_reg[a];
                mx3_reg[a] <= mx2_reg[a];
                e_reg[a]   <= E_W'(pe_reg[a][0]) + E_W'(pe_reg[a][1]) + E_W'(pe_reg[a][2]);
                f_reg[a]   <= F_W'(pf_reg[a][0]) + F_W'(pf_reg[a][1]) + F_W'(pf_reg[a][2]);
            end
        end
    end

    // Stage 4: plane numerators, parallel test and the slab test for parallel rays.
    n_t               nmn_next [NAXIS];
    n_t               nmx_next [NAXIS];
    logic [DEN_W-1:0] af_next  [NAXIS];
    logic [DEN_W-1:0] eps_sh;

    always_comb
    begin
        eps_sh = DEN_W'({eps, {FRAC_W{1'b0}}});
        for (int a = 0; a < NAXIS; a++)
        begin
            nmn_next[a] = N_W'(e_reg[a]) + (N_W'(mn3_reg[a]) <<< FRAC_W);
            nmx_next[a] = N_W'(e_reg[a]) + (N_W'(mx3_reg[a]) <<< FRAC_W);
            af_next[a]  = DEN_W'(f_reg[a][F_W-1] ? -f_reg[a] : f_reg[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NAXIS; a++)
            begin
                nmn_reg[a]  <= nmn_next[a];
                nmx_reg[a]  <= nmx_next[a];
                af_reg[a]   <= af_next[a];
                sf_reg[a]   <= f_reg[a][F_W-1];
                par_reg[a]  <= af_next[a] <= eps_sh;
                prej_reg[a] <= (nmn_next[a] > 0) || (nmx_next[a] < 0);
            end
        end
    end

    // Stage 5: magnitudes shifted so the quotients come out in Q.8, overflow of the quotient range, cell seeds.
    logic [N_W-1:0] mag     [0:2*NAXIS-1];
    logic [D_W-1:0] dvd     [0:2*NAXIS-1];
    div_t           div_next[0:2*NAXIS-1];
    side_t          side_next;

    always_comb
    begin
        side_next        = side_reg;
        side_next.par    = par_reg;
        side_next.prej   = prej_reg;
        for (int a = 0; a < NAXIS; a++)
        begin
            mag[2*a]   = N_W'(nmn_reg[a][N_W-1] ? -nmn_reg[a] : nmn_reg[a]);
            mag[2*a+1] = N_W'(nmx_reg[a][N_W-1] ? -nmx_reg[a] : nmx_reg[a]);
            side_next.neg_mn[a] = nmn_reg[a][N_W-1] ^ sf_reg[a];
            side_next.neg_mx[a] = nmx_reg[a][N_W-1] ^ sf_reg[a];
        end
        for (int l = 0; l < 2*NAXIS; l++)
        begin
            dvd[l]          = {mag[l], {DIST_FRAC{1'b0}}};
            div_next[l].rem = DEN_W'(dvd[l][D_W-1:Q_W]);
            div_next[l].num = dvd[l][Q_W-1:0];
            div_next[l].quo = '0;
            div_next[l].den = af_reg[l/2];
        end
        for (int a = 0; a < NAXIS; a++)
        begin
            side_next.ovf_mn[a] = div_next[2*a].rem >= af_reg[a];
            side_next.ovf_mx[a] = div_next[2*a+1].rem >= af_reg[a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            for (int l = 0; l < 2*NAXIS; l++)
            begin
                div_reg[l] <= div_next[l];
            end
        end
    end

    assign div_out = div_reg;
    assign side    = side_reg;

endmodule

/* rtl/ray_obb_slab_intersect.sv */
// Throughput: one box per cycle while the skid stage is empty; 5 setup stages, a 34-cell
// divider chain, 4 interval stages. The divider chain (one quotient bit per cell) sets the
// depth; a skid stage holds one more result beat while the output beat waits. Reset (rst_n
// low, asynchronous) empties the pipeline and loads origin 0, direction 0, epsilon 4 and far
// limit 100000.0.
`include "assert_macros.svh"

module ray_obb_slab_intersect
    import rosi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_t              out_data
);

    typedef logic signed [T_W-1:0] t_t;

    typedef struct packed {
        logic signed [T_W-1:0] lo;
        logic signed [T_W-1:0] hi;
        logic                  par;
        logic                  prej;
    } axis_t;

    typedef struct packed {
        axis_t [NAXIS-1:0]     ax;
        logic signed [T_W-1:0] tmin;
        logic signed [T_W-1:0] tmax;
        logic                  hit;
    } track_t;

    localparam t_t T_SAT = t_t'(1) <<< Q_W;

    // Configuration registers.
    logic [VEC_W-1:0]  origin_reg;
    logic [VEC_W-1:0]  dir_reg;
    logic [EPS_W-1:0]  eps_reg;
    logic [DIST_W-1:0] far_reg;
    reg_idx_t          cfg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= '0;
            dir_reg    <= '0;
            eps_reg    <= EPS_RESET;
            far_reg    <= FAR_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ORIGIN: origin_reg <= pwdata[VEC_W-1:0];
                REG_DIR:    dir_reg    <= pwdata[VEC_W-1:0];
                REG_EPS:    eps_reg    <= pwdata[EPS_W-1:0];
                REG_FAR:    far_reg    <= pwdata[DIST_W-1:0];
                default:    far_reg    <= far_reg;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (cfg_idx)
            REG_ORIGIN: prdata = CFG_W'(origin_reg);
            REG_DIR:    prdata = CFG_W'(dir_reg);
            REG_EPS:    prdata = CFG_W'(eps_reg);
            REG_FAR:    prdata = CFG_W'(far_reg);
            default:    prdata = '0;
        endcase
    end

    // The whole pipeline moves unless the skid stage holds a beat.
    logic en;
    logic skid_vld_reg;
    logic out_vld_reg;
    out_t out_reg;
    out_t skid_reg;
    logic [PIPE_D-1:0] vld_reg;

    assign en       = !skid_vld_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_D-2:0], in_valid};
        end
    end

    // Setup stages.
    div_t  seed [0:2*NAXIS-1];
    side_t side_front;

    rosi_front u_front (
        .clk       (clk),
        .en        (en),
        .in_data   (in_data),
        .origin    (origin_reg),
        .direction (dir_reg),
        .eps       (eps_reg),
        .div_out   (seed),
        .side      (side_front)
    );

    // Six divider chains: near and far plane for each axis.
    div_t quot [0:2*NAXIS-1];

    for (genvar l = 0; l < 2*NAXIS; l++)
    begin : g_div
        rosi_div_chain u_chain (
            .clk   (clk),
            .en    (en),
            .first (seed[l]),
            .last  (quot[l])
        );
    end

    // Flags ride beside the divider chain.
    side_t side_pipe_reg [0:Q_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_pipe_reg[0] <= side_front;
            for (int i = 1; i < Q_W; i++)
            begin
                side_pipe_reg[i] <= side_pipe_reg[i-1];
            end
        end
    end

    // Signed, saturated plane distances, ordered per axis.
    side_t  sd;
    t_t     t_mn [NAXIS];
    t_t     t_mx [NAXIS];
    track_t trk_next0;
    track_t trk_reg [0:NAXIS];
    track_t trk_next [0:NAXIS-1];

    always_comb
    begin
        sd = side_pipe_reg[Q_W-1];
        trk_next0      = trk_reg[0];
        trk_next0.tmin = '0;
        trk_next0.tmax = t_t'(far_reg);
        trk_next0.hit  = 1'b1;
        for (int a = 0; a < NAXIS; a++)
        begin
            if (sd.ovf_mn[a])
                t_mn[a] = sd.neg_mn[a] ? -T_SAT : T_SAT;
            else
                t_mn[a] = sd.neg_mn[a] ? -t_t'(quot[2*a].quo) : t_t'(quot[2*a].quo);
            if (sd.ovf_mx[a])
                t_mx[a] = sd.neg_mx[a] ? -T_SAT : T_SAT;
            else
                t_mx[a] = sd.neg_mx[a] ? -t_t'(quot[2*a+1].quo) : t_t'(quot[2*a+1].quo);
            trk_next0.ax[a].lo   = (t_mn[a] > t_mx[a]) ? t_mx[a] : t_mn[a];
            trk_next0.ax[a].hi   = (t_mn[a] > t_mx[a]) ? t_mn[a] : t_mx[a];
            trk_next0.ax[a].par  = sd.par[a];
            trk_next0.ax[a].prej = sd.prej[a];
        end
    end

    // Interval update, one axis per stage.
    for (genvar k = 0; k < NAXIS; k++)
    begin : g_axis
        t_t lo;
        t_t hi;
        t_t tmin_c;
        t_t tmax_c;
        t_t nmin;
        t_t nmax;

        always_comb
        begin
            lo          = trk_reg[k].ax[k].lo;
            hi          = trk_reg[k].ax[k].hi;
            tmin_c      = trk_reg[k].tmin;
            tmax_c      = trk_reg[k].tmax;
            nmax        = (hi < tmax_c) ? hi : tmax_c;
            nmin        = (lo > tmin_c) ? lo : tmin_c;
            trk_next[k] = trk_reg[k];
            if (!trk_reg[k].ax[k].par)
            begin
                trk_next[k].tmin = nmin;
                trk_next[k].tmax = nmax;
                if (nmax < nmin)
                    trk_next[k].hit = 1'b0;
            end
            else if (trk_reg[k].ax[k].prej)
            begin
                trk_next[k].hit = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trk_reg[0] <= trk_next0;
            for (int k = 0; k < NAXIS; k++)
            begin
                trk_reg[k+1] <= trk_next[k];
            end
        end
    end

    // Clamp the near bound and zero it on a miss.
    out_t res;
    t_t   tfin;

    always_comb
    begin
        tfin     = trk_reg[NAXIS].tmin;
        res.hit  = trk_reg[NAXIS].hit;
        if (!trk_reg[NAXIS].hit)
            res.distance = '0;
        else if (tfin > t_t'(far_reg))
            res.distance = far_reg;
        else
            res.distance = tfin[DIST_W-1:0];
    end

    // Output register with one skid beat behind it.
    logic push;
    logic take;

    assign push = en && vld_reg[PIPE_D-1];
    assign take = out_vld_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || take)
        begin
            out_vld_reg  <= skid_vld_reg || push;
            skid_vld_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || take)
        begin
            out_reg <= skid_vld_reg ? skid_reg : res;
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // Checks on the output buffer and the result format.
    `ASSERT_IMPL(a_skid_needs_out, clk, rst_n, skid_vld_reg, out_vld_reg)
    `ASSERT_IMPL(a_miss_zero, clk, rst_n, out_vld_reg && !out_reg.hit, out_reg.distance == '0)
    `ASSERT_IMPL(a_dist_clamped, clk, rst_n, out_vld_reg && out_reg.hit, out_reg.distance <= far_reg)
    `ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, out_vld_reg && !out_ready && push, skid_vld_reg)

endmodule
